/* rtl/ofcc_pkg.sv */
// Shared types, constants and lookup functions for the optical flow color coder.
package ofcc_pkg;

    localparam int FLOW_FRAC_BITS = 5;
    localparam int CORDIC_STEPS   = 14;
    localparam int ROOT_ITERS     = 30;
    localparam int WHEEL_SIZE     = 55;

    localparam logic [15:0] ONE_Q14     = 16'd16384;
    localparam logic [15:0] MAX_ROOT    = 16'd46340;
    localparam logic [15:0] UNIT_DIV    = 16'(1 << FLOW_FRAC_BITS);
    localparam logic [23:0] PHASE_SCALE = 24'(WHEEL_SIZE - 1);
    localparam logic [63:0] BLEND_FULL  = 64'(255) << 16;
    localparam logic [63:0] WHITE_Q30   = 64'(255) << 30;
    localparam logic [14:0] LIMIT_RST   = 15'd32767;

    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_PAINT   = 1'b1;

    // register select is address bit 2
    localparam logic REG_LIMIT = 1'b0;
    localparam logic REG_NORM  = 1'b1;

    typedef struct packed {
        logic        func;
        logic        frame_start;
        logic signed [15:0] flow_x;
        logic signed [15:0] flow_y;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       unknown;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic        func;
        logic        bad;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] divisor;
    } t_eng_job;

    typedef struct packed {
        logic        func;
        logic        bad;
        logic [15:0] radius;
        t_rgb        rgb;
    } t_eng_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQSUM,
        ST_SQRT,
        ST_DIV,
        ST_CORD,
        ST_WHEEL,
        ST_SPLIT,
        ST_BLEND,
        ST_DONE
    } t_eng_state;

    function automatic logic [15:0] abs16(input logic [15:0] v);
        abs16 = v[15] ? 16'(~v + 16'd1) : v;
    endfunction

    // arctangent of 2^-i as a fraction of a full turn, 16 bits
    function automatic logic [15:0] atan_turn(input logic [3:0] idx);
        case (idx)
            4'd0:    atan_turn = 16'd8192;
            4'd1:    atan_turn = 16'd4836;
            4'd2:    atan_turn = 16'd2555;
            4'd3:    atan_turn = 16'd1297;
            4'd4:    atan_turn = 16'd651;
            4'd5:    atan_turn = 16'd326;
            4'd6:    atan_turn = 16'd163;
            4'd7:    atan_turn = 16'd81;
            4'd8:    atan_turn = 16'd41;
            4'd9:    atan_turn = 16'd20;
            4'd10:   atan_turn = 16'd10;
            4'd11:   atan_turn = 16'd5;
            4'd12:   atan_turn = 16'd3;
            4'd13:   atan_turn = 16'd1;
            default: atan_turn = 16'd0;
        endcase
    endfunction

    // color wheel: red-yellow 15, yellow-green 6, green-cyan 4,
    // cyan-blue 11, blue-magenta 13, magenta-red 6
    function automatic t_rgb wheel_lut(input logic [5:0] k);
        case (k)
            6'd0:    wheel_lut = {8'd255, 8'd0,   8'd0};
            6'd1:    wheel_lut = {8'd255, 8'd17,  8'd0};
            6'd2:    wheel_lut = {8'd255, 8'd34,  8'd0};
            6'd3:    wheel_lut = {8'd255, 8'd51,  8'd0};
            6'd4:    wheel_lut = {8'd255, 8'd68,  8'd0};
            6'd5:    wheel_lut = {8'd255, 8'd85,  8'd0};
            6'd6:    wheel_lut = {8'd255, 8'd102, 8'd0};
            6'd7:    wheel_lut = {8'd255, 8'd119, 8'd0};
            6'd8:    wheel_lut = {8'd255, 8'd136, 8'd0};
            6'd9:    wheel_lut = {8'd255, 8'd153, 8'd0};
            6'd10:   wheel_lut = {8'd255, 8'd170, 8'd0};
            6'd11:   wheel_lut = {8'd255, 8'd187, 8'd0};
            6'd12:   wheel_lut = {8'd255, 8'd204, 8'd0};
            6'd13:   wheel_lut = {8'd255, 8'd221, 8'd0};
            6'd14:   wheel_lut = {8'd255, 8'd238, 8'd0};
            6'd15:   wheel_lut = {8'd255, 8'd255, 8'd0};
            6'd16:   wheel_lut = {8'd213, 8'd255, 8'd0};
            6'd17:   wheel_lut = {8'd170, 8'd255, 8'd0};
            6'd18:   wheel_lut = {8'd128, 8'd255, 8'd0};
            6'd19:   wheel_lut = {8'd85,  8'd255, 8'd0};
            6'd20:   wheel_lut = {8'd43,  8'd255, 8'd0};
            6'd21:   wheel_lut = {8'd0,   8'd255, 8'd0};
            6'd22:   wheel_lut = {8'd0,   8'd255, 8'd63};
            6'd23:   wheel_lut = {8'd0,   8'd255, 8'd127};
            6'd24:   wheel_lut = {8'd0,   8'd255, 8'd191};
            6'd25:   wheel_lut = {8'd0,   8'd255, 8'd255};
            6'd26:   wheel_lut = {8'd0,   8'd232, 8'd255};
            6'd27:   wheel_lut = {8'd0,   8'd209, 8'd255};
            6'd28:   wheel_lut = {8'd0,   8'd186, 8'd255};
            6'd29:   wheel_lut = {8'd0,   8'd163, 8'd255};
            6'd30:   wheel_lut = {8'd0,   8'd140, 8'd255};
            6'd31:   wheel_lut = {8'd0,   8'd116, 8'd255};
            6'd32:   wheel_lut = {8'd0,   8'd93,  8'd255};
            6'd33:   wheel_lut = {8'd0,   8'd70,  8'd255};
            6'd34:   wheel_lut = {8'd0,   8'd47,  8'd255};
            6'd35:   wheel_lut = {8'd0,   8'd24,  8'd255};
            6'd36:   wheel_lut = {8'd0,   8'd0,   8'd255};
            6'd37:   wheel_lut = {8'd19,  8'd0,   8'd255};
            6'd38:   wheel_lut = {8'd39,  8'd0,   8'd255};
            6'd39:   wheel_lut = {8'd58,  8'd0,   8'd255};
            6'd40:   wheel_lut = {8'd78,  8'd0,   8'd255};
            6'd41:   wheel_lut = {8'd98,  8'd0,   8'd255};
            6'd42:   wheel_lut = {8'd117, 8'd0,   8'd255};
            6'd43:   wheel_lut = {8'd137, 8'd0,   8'd255};
            6'd44:   wheel_lut = {8'd156, 8'd0,   8'd255};
            6'd45:   wheel_lut = {8'd176, 8'd0,   8'd255};
            6'd46:   wheel_lut = {8'd196, 8'd0,   8'd255};
            6'd47:   wheel_lut = {8'd215, 8'd0,   8'd255};
            6'd48:   wheel_lut = {8'd235, 8'd0,   8'd255};
            6'd49:   wheel_lut = {8'd255, 8'd0,   8'd255};
            6'd50:   wheel_lut = {8'd255, 8'd0,   8'd213};
            6'd51:   wheel_lut = {8'd255, 8'd0,   8'd170};
            6'd52:   wheel_lut = {8'd255, 8'd0,   8'd128};
            6'd53:   wheel_lut = {8'd255, 8'd0,   8'd85};
            default: wheel_lut = {8'd255, 8'd0,   8'd43};
        endcase
    endfunction

endpackage

/* rtl/ofcc_addsub.sv */
// Shared 64-bit adder/subtractor with carry out (carry set on subtract means no borrow).
module ofcc_addsub (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic        i_sub,
    output logic [64:0] o_sum
);
    import ofcc_pkg::*;

    logic [64:0] b_ext;

    assign b_ext = i_sub ? {1'b0, ~i_b} : {1'b0, i_b};
    assign o_sum = {1'b0, i_a} + b_ext + 65'(i_sub);

endmodule

/* rtl/ofcc_mul.sv */
// Shared 17 x 24 unsigned multiplier.
module ofcc_mul (
    input  logic [16:0] i_a,
    input  logic [23:0] i_b,
    output logic [40:0] o_p
);
    import ofcc_pkg::*;

    assign o_p = 41'(i_a) * 41'(i_b);

endmodule

/* rtl/ofcc_engine.sv */
// Sequencer and datapath: square, root, divide, CORDIC and wheel blend on shared units.
module ofcc_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ofcc_pkg::t_eng_job  i_job,
    input  logic                i_ack,
    output logic                o_done,
    output ofcc_pkg::t_eng_rsp  o_rsp
);
    import ofcc_pkg::*;

    t_eng_state         r_state, n_state;
    logic [4:0]         r_cnt, n_cnt;
    logic [2:0]         r_sub, n_sub;
    logic [1:0]         r_ch, n_ch;
    logic               r_func, n_func;
    logic               r_bad, n_bad;
    logic               r_dir, n_dir;
    logic [15:0]        r_fx, n_fx;
    logic [15:0]        r_fy, n_fy;
    logic [15:0]        r_div, n_div;
    logic [59:0]        r_v, n_v;
    logic [59:0]        r_res, n_res;
    logic signed [32:0] r_x, n_x;
    logic signed [32:0] r_y, n_y;
    logic signed [32:0] r_tx, n_tx;
    logic [15:0]        r_z, n_z;
    logic [40:0]        r_prod, n_prod;
    logic [5:0]         r_k0, n_k0;
    logic [15:0]        r_f, n_f;
    logic [15:0]        r_rad, n_rad;
    logic [15:0]        r_radius, n_radius;
    logic [2:0][7:0]    r_rgb, n_rgb;

    logic [63:0]        add_a, add_b;
    logic               add_sub;
    logic [64:0]        add_sum;
    logic [16:0]        mul_a;
    logic [23:0]        mul_b;
    logic [40:0]        mul_p;

    logic [59:0]        root_bit;
    logic [59:0]        root_next;
    logic [16:0]        rem_sh;
    logic [29:0]        q_full;
    logic signed [32:0] x0, y0;
    logic signed [32:0] cord_dx, cord_dy;
    t_rgb               c0, c1;
    logic [7:0]         c0ch, c1ch, chan;

    ofcc_addsub u_addsub (
        .i_a   (add_a),
        .i_b   (add_b),
        .i_sub (add_sub),
        .o_sum (add_sum)
    );

    ofcc_mul u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    assign root_bit  = 60'd1 << {r_cnt, 1'b0};
    assign root_next = add_sum[64] ? ((r_res >> 1) | root_bit) : (r_res >> 1);
    assign rem_sh    = {r_v[15:0], r_res[29]};
    assign q_full    = {r_res[28:0], add_sum[64]};
    assign x0        = {{3{r_fx[15]}}, r_fx, 14'd0};
    assign y0        = {{3{r_fy[15]}}, r_fy, 14'd0};
    assign cord_dx   = r_y >>> r_cnt[3:0];
    assign cord_dy   = r_x >>> r_cnt[3:0];
    assign c0        = wheel_lut(r_k0);
    assign c1        = wheel_lut(r_k0 + 6'd1);

    always_comb begin
        case (r_ch)
            2'd0:    begin c0ch = c0.red;   c1ch = c1.red;   end
            2'd1:    begin c0ch = c0.green; c1ch = c1.green; end
            default: begin c0ch = c0.blue;  c1ch = c1.blue;  end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sub    = r_sub;
        n_ch     = r_ch;
        n_func   = r_func;
        n_bad    = r_bad;
        n_dir    = r_dir;
        n_fx     = r_fx;
        n_fy     = r_fy;
        n_div    = r_div;
        n_v      = r_v;
        n_res    = r_res;
        n_x      = r_x;
        n_y      = r_y;
        n_tx     = r_tx;
        n_z      = r_z;
        n_prod   = r_prod;
        n_k0     = r_k0;
        n_f      = r_f;
        n_rad    = r_rad;
        n_radius = r_radius;
        n_rgb    = r_rgb;
        add_a    = '0;
        add_b    = '0;
        add_sub  = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        chan     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_func = i_job.func;
                    n_bad  = i_job.bad;
                    n_fx   = i_job.fx;
                    n_fy   = i_job.fy;
                    n_div  = i_job.divisor;
                    n_rgb  = '0;
                    n_state = i_job.bad ? ST_DONE : ST_SQX;
                end
            end
            ST_SQX: begin
                mul_a  = 17'(abs16(r_fx));
                mul_b  = 24'(abs16(r_fx));
                n_prod = mul_p;
                n_state = ST_SQY;
            end
            ST_SQY: begin
                n_v    = 60'(r_prod);
                mul_a  = 17'(abs16(r_fy));
                mul_b  = 24'(abs16(r_fy));
                n_prod = mul_p;
                n_state = ST_SQSUM;
            end
            ST_SQSUM: begin
                add_a = 64'(r_v);
                add_b = 64'(r_prod);
                // scale by 2^28 so the root comes out in Q.14
                n_v   = {add_sum[31:0], 28'd0};
                n_res = '0;
                n_cnt = 5'(ROOT_ITERS - 1);
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                add_a   = 64'(r_v);
                add_b   = 64'(r_res | root_bit);
                add_sub = 1'b1;
                if (add_sum[64]) begin
                    n_v = add_sum[59:0];
                end
                n_res = root_next;
                if (r_cnt == 5'd0) begin
                    if (r_func == FUNC_MEASURE) begin
                        n_radius = root_next[29:14];
                        n_state  = ST_DONE;
                    end else begin
                        n_v     = '0;
                        n_cnt   = 5'(ROOT_ITERS - 1);
                        n_state = ST_DIV;
                    end
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            ST_DIV: begin
                add_a   = 64'(rem_sh);
                add_b   = 64'(r_div);
                add_sub = 1'b1;
                n_v     = 60'(add_sum[64] ? add_sum[16:0] : rem_sh);
                n_res   = 60'(q_full);
                if (r_cnt == 5'd0) begin
                    n_rad = (|q_full[29:16]) ? 16'hFFFF : q_full[15:0];
                    n_cnt = '0;
                    n_sub = '0;
                    if (r_fx == 16'd0 && r_fy == 16'd0) begin
                        // zero vector: phase is zero
                        n_z     = '0;
                        n_state = ST_WHEEL;
                    end else begin
                        if (r_fx[15]) begin
                            n_x = -x0;
                            n_y = -y0;
                            n_z = 16'h8000;
                        end else begin
                            n_x = x0;
                            n_y = y0;
                            n_z = '0;
                        end
                        n_state = ST_CORD;
                    end
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            ST_CORD: begin
                case (r_sub)
                    3'd0: begin
                        add_a   = 64'(r_x);
                        add_b   = 64'(cord_dx);
                        add_sub = r_y[32];
                        n_tx    = add_sum[32:0];
                        n_dir   = ~r_y[32];
                        n_sub   = 3'd1;
                    end
                    3'd1: begin
                        add_a   = 64'(r_y);
                        add_b   = 64'(cord_dy);
                        add_sub = r_dir;
                        n_y     = add_sum[32:0];
                        n_sub   = 3'd2;
                    end
                    default: begin
                        n_x     = r_tx;
                        add_a   = 64'(r_z);
                        add_b   = 64'(atan_turn(r_cnt[3:0]));
                        add_sub = ~r_dir;
                        n_z     = add_sum[15:0];
                        n_sub   = 3'd0;
                        if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                            n_state = ST_WHEEL;
                        end else begin
                            n_cnt = r_cnt + 5'd1;
                        end
                    end
                endcase
            end
            ST_WHEEL: begin
                mul_a  = 17'(r_z);
                mul_b  = PHASE_SCALE;
                n_prod = mul_p;
                n_state = ST_SPLIT;
            end
            ST_SPLIT: begin
                n_k0  = r_prod[21:16];
                n_f   = r_prod[15:0];
                n_ch  = '0;
                n_sub = '0;
                n_state = ST_BLEND;
            end
            ST_BLEND: begin
                case (r_sub)
                    3'd0: begin
                        mul_a  = 17'h10000 - 17'(r_f);
                        mul_b  = 24'(c0ch);
                        n_prod = mul_p;
                        n_sub  = 3'd1;
                    end
                    3'd1: begin
                        n_v    = 60'(r_prod);
                        mul_a  = 17'(r_f);
                        mul_b  = 24'(c1ch);
                        n_prod = mul_p;
                        n_sub  = 3'd2;
                    end
                    3'd2: begin
                        add_a = 64'(r_v);
                        add_b = 64'(r_prod);
                        n_v   = 60'(add_sum[24:0]);
                        n_sub = 3'd3;
                    end
                    3'd3: begin
                        if (r_rad <= ONE_Q14) begin
                            add_a   = BLEND_FULL;
                            add_b   = 64'(r_v);
                            add_sub = 1'b1;
                            n_v     = 60'(add_sum[23:0]);
                            n_sub   = 3'd4;
                        end else begin
                            // over-range: 0.75 of the blend
                            add_a = 64'(r_v);
                            add_b = 64'({r_v, 1'b0});
                            chan  = add_sum[25:18];
                            n_rgb[r_ch] = chan;
                            n_sub = 3'd0;
                            if (r_ch == 2'd2) begin
                                n_state = ST_DONE;
                            end else begin
                                n_ch = r_ch + 2'd1;
                            end
                        end
                    end
                    3'd4: begin
                        mul_a  = 17'(r_rad);
                        mul_b  = r_v[23:0];
                        n_prod = mul_p;
                        n_sub  = 3'd5;
                    end
                    default: begin
                        add_a   = WHITE_Q30;
                        add_b   = 64'(r_prod);
                        add_sub = 1'b1;
                        chan    = add_sum[37:30];
                        n_rgb[r_ch] = chan;
                        n_sub   = 3'd0;
                        if (r_ch == 2'd2) begin
                            n_state = ST_DONE;
                        end else begin
                            n_ch = r_ch + 2'd1;
                        end
                    end
                endcase
            end
            ST_DONE: begin
                if (i_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_sub    <= n_sub;
        r_ch     <= n_ch;
        r_func   <= n_func;
        r_bad    <= n_bad;
        r_dir    <= n_dir;
        r_fx     <= n_fx;
        r_fy     <= n_fy;
        r_div    <= n_div;
        r_v      <= n_v;
        r_res    <= n_res;
        r_x      <= n_x;
        r_y      <= n_y;
        r_tx     <= n_tx;
        r_z      <= n_z;
        r_prod   <= n_prod;
        r_k0     <= n_k0;
        r_f      <= n_f;
        r_rad    <= n_rad;
        r_radius <= n_radius;
        r_rgb    <= n_rgb;
    end

    assign o_done        = (r_state == ST_DONE);
    assign o_rsp.func    = r_func;
    assign o_rsp.bad     = r_bad;
    assign o_rsp.radius  = r_radius;
    assign o_rsp.rgb.red   = r_rgb[0];
    assign o_rsp.rgb.green = r_rgb[1];
    assign o_rsp.rgb.blue  = r_rgb[2];

endmodule

/* rtl/optical_flow_color_coder.sv */
// Top level of the optical flow color coder: register port, item handshake, maximum radius.
// A paint item runs the 30-step root, the 30-step divide, 14 CORDIC steps and a blend per
// channel before its result; a measure item gives no result and frees the engine after the
// root. An unknown vector goes straight to the result, a zero vector skips the CORDIC, and a
// normalized radius above one shortens the blend. The next item is accepted in the cycle after
// the engine hands off its result, and that hand-off waits on any output stall. Reset
// (synchronous, active low) clears the maximum radius, sets the unknown limit to 32767 and
// enables normalization.
module optical_flow_color_coder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ofcc_pkg::t_in_item   i_in,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ofcc_pkg::t_out_item  o_out,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import ofcc_pkg::*;

    logic [14:0] r_limit;
    logic        r_norm;
    logic [15:0] r_max_radius;
    logic        r_busy;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        in_accept;
    logic        cfg_write;
    logic [15:0] abs_x, abs_y;
    logic        vec_valid;
    logic [15:0] divisor;
    t_eng_job    eng_job;
    logic        eng_done;
    logic        eng_ack;
    t_eng_rsp    eng_rsp;

    // ---------------------------------------------------------------
    // Register port: zero-wait, decode on address bit 2 only.
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
            r_norm  <= 1'b1;
        end else if (cfg_write) begin
            if (paddr[2] == REG_LIMIT) begin
                r_limit <= pwdata[14:0];
            end else begin
                r_norm <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_NORM) ? {31'd0, r_norm} : {17'd0, r_limit};

    // ---------------------------------------------------------------
    // Item intake: qualify the vector and pick the divisor at accept.
    // The engine runs one item at a time; hold ready low while busy.
    // ---------------------------------------------------------------
    assign o_in_ready = ~r_busy;
    assign in_accept  = i_in_valid && o_in_ready;

    assign abs_x     = abs16(i_in.flow_x);
    assign abs_y     = abs16(i_in.flow_y);
    // limit applies to the raw components; the most negative code always fails
    assign vec_valid = (abs_x <= {1'b0, r_limit}) && (abs_y <= {1'b0, r_limit});
    assign divisor   = r_norm ? r_max_radius : UNIT_DIV;

    assign eng_job.func    = i_in.func;
    assign eng_job.bad     = ~vec_valid || (i_in.func == FUNC_PAINT && divisor == 16'd0);
    assign eng_job.fx      = i_in.flow_x;
    assign eng_job.fy      = i_in.flow_y;
    assign eng_job.divisor = divisor;

    ofcc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_job   (eng_job),
        .i_ack   (eng_ack),
        .o_done  (eng_done),
        .o_rsp   (eng_rsp)
    );

    // Engine result is taken when the output register is free or drains this cycle.
    assign eng_ack = ~r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_accept) begin
            r_busy <= 1'b1;
        end else if (eng_done && eng_ack) begin
            r_busy <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Maximum radius: clear on a frame-start measure item at accept,
    // raise on a valid measure result.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_radius <= '0;
        end else if (in_accept && i_in.func == FUNC_MEASURE && i_in.frame_start) begin
            r_max_radius <= '0;
        end else if (eng_done && eng_ack && eng_rsp.func == FUNC_MEASURE && !eng_rsp.bad &&
                     eng_rsp.radius > r_max_radius) begin
            r_max_radius <= eng_rsp.radius;
        end
    end

    // ---------------------------------------------------------------
    // Output register: one paint result, parts the engine from the sink.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done && eng_ack && eng_rsp.func == FUNC_PAINT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done && eng_ack && eng_rsp.func == FUNC_PAINT) begin
            r_out.red     <= eng_rsp.rgb.red;
            r_out.green   <= eng_rsp.rgb.green;
            r_out.blue    <= eng_rsp.rgb.blue;
            r_out.unknown <= eng_rsp.bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_done |-> r_busy)
        else $error("engine done without an item in flight");

    a_max_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_radius <= MAX_ROOT)
        else $error("maximum radius beyond largest possible root");

    a_paint_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eng_done && eng_ack && eng_rsp.func == FUNC_PAINT) |=> o_out_valid)
        else $error("paint result not presented");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eng_done && !eng_ack) |=> (eng_done && !o_in_ready))
        else $error("engine released result without acknowledge");
`endif

endmodule

/* verif/tb_optical_flow_color_coder.sv */
// Self-checking testbench for the optical flow color coder: directed table plus random items.
`timescale 1ns / 100ps

module tb_optical_flow_color_coder;
    import ofcc_pkg::*;

    // Register byte addresses: register i sits at 4*i.
    localparam logic [2:0] ADDR_LIMIT = 3'd0;
    localparam logic [2:0] ADDR_NORM  = 3'd4;
    // Quiet time before a register write: a measure item yields no result and
    // may still be in flight, so allow its full latency and then some.
    localparam int MEASURE_DRAIN = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    optical_flow_color_coder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Shadow copy of the block's registers and its running maximum radius.
    logic [14:0] shadow_limit;
    logic        shadow_norm;
    logic [15:0] shadow_max_radius;

    // Colors predicted for paint items, oldest first.
    t_out_item   pending_colors[$];
    int          fail_count;
    bit          out_stall_enable;

    always #5 i_clk = ~i_clk;

    // Hard limit: ~1000 items, each with its work and long gaps on both sides,
    // stay well below this.
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (v >= root + bitpos) begin
                v = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // Floor division by 2^s for signed values (arithmetic shift is a floor).
    function automatic longint floor_div_pow2(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic int turn_step(input int i);
        int steps[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        return steps[i];
    endfunction

    // Angle of the vector as a 16-bit fraction of a turn, by vectoring CORDIC.
    function automatic logic [15:0] flow_phase(input int fx, input int fy);
        longint x;
        longint y;
        longint dx;
        longint dy;
        int     z;
        x = longint'(fx) * 16384;
        y = longint'(fy) * 16384;
        z = 0;
        if (fx == 0 && fy == 0) return 16'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32768;
        end
        for (int i = 0; i < 14; i++) begin
            dx = floor_div_pow2(y, i);
            dy = floor_div_pow2(x, i);
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + turn_step(i);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - turn_step(i);
            end
        end
        return z[15:0];
    endfunction

    // Color wheel entry k, built from the segment lengths.
    function automatic void wheel_color(input int k, output int c[3]);
        if (k < 15) begin
            c = '{255, 255 * k / 15, 0};
            return;
        end
        k -= 15;
        if (k < 6) begin
            c = '{255 - 255 * k / 6, 255, 0};
            return;
        end
        k -= 6;
        if (k < 4) begin
            c = '{0, 255, 255 * k / 4};
            return;
        end
        k -= 4;
        if (k < 11) begin
            c = '{0, 255 - 255 * k / 11, 255};
            return;
        end
        k -= 11;
        if (k < 13) begin
            c = '{255 * k / 13, 0, 255};
            return;
        end
        k -= 13;
        if (k >= 6) k = 5;
        c = '{255, 0, 255 - 255 * k / 6};
    endfunction

    // Apply one accepted item to the shadow state; return 1 with a color for paint.
    function automatic bit predict_item(input t_in_item it, output t_out_item color);
        int          fx;
        int          fy;
        int          ax;
        int          ay;
        bit          ok;
        logic [63:0] sq;
        logic [63:0] rad;
        logic [63:0] divisor;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] mix;
        logic [63:0] v;
        int          k0;
        int          frac;
        int          c0[3];
        int          c1[3];
        fx = int'(it.flow_x);
        fy = int'(it.flow_y);
        ax = fx < 0 ? -fx : fx;
        ay = fy < 0 ? -fy : fy;
        ok = ax <= shadow_limit && ay <= shadow_limit;
        sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
        color = '0;
        if (it.func == FUNC_MEASURE) begin
            if (it.frame_start) shadow_max_radius = 16'd0;
            if (ok) begin
                rad = int_sqrt(sq);
                if (rad > shadow_max_radius) shadow_max_radius = rad[15:0];
            end
            return 1'b0;
        end
        divisor = shadow_norm ? 64'(shadow_max_radius) : 64'(1 << FLOW_FRAC_BITS);
        if (!ok || divisor == 0) begin
            color.unknown = 1'b1;
            return 1'b1;
        end
        r = int_sqrt(sq << 28) / divisor;
        if (r > 65535) r = 65535;
        t = 64'(flow_phase(fx, fy)) * 54;
        k0 = int'(t >> 16);
        frac = int'(t & 64'hFFFF);
        wheel_color(k0, c0);
        wheel_color((k0 + 1) % 55, c1);
        for (int ch = 0; ch < 3; ch++) begin
            mix = 64'(65536 - frac) * 64'(c0[ch]) + 64'(frac) * 64'(c1[ch]);
            if (r <= 16384) v = ((64'd255 << 30) - r * ((64'd255 << 16) - mix)) >> 30;
            else v = (3 * mix) >> 18;
            case (ch)
                0: color.red = v[7:0];
                1: color.green = v[7:0];
                default: color.blue = v[7:0];
            endcase
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge i_clk);
    endtask

    // Mostly short gaps, sometimes none, occasionally long.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LIMIT) shadow_limit = data[14:0];
        else if (addr == ADDR_NORM) shadow_norm = data[0];
        @(posedge i_clk);
    endtask

    // Hand one item to the block and record the color it should produce.
    // Drive at the clock edge that follows the previous handshake; the block is busy then anyway.
    task automatic send_item(input t_in_item it);
        t_out_item color;
        @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (predict_item(it, color)) pending_colors.insert(pending_colors.size(), color);
        i_in_valid <= 1'b0;
    endtask

    task automatic send_with_gap(input t_in_item it);
        idle_cycles(gap_length());
        send_item(it);
    endtask

    // Wait for all colors, then let any trailing measure item finish.
    task automatic drain();
        int guard;
        guard = 0;
        while (pending_colors.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        idle_cycles(MEASURE_DRAIN);
    endtask

    task automatic set_regs(input logic [14:0] limit, input logic norm);
        drain();
        reg_write(ADDR_LIMIT, 32'(limit));
        reg_write(ADDR_NORM, 32'(norm));
    endtask

    function automatic t_in_item make_item(input logic func, input logic start,
                                           input logic [15:0] fx, input logic [15:0] fy);
        t_in_item it;
        it.func        = func;
        it.frame_start = start;
        it.flow_x      = fx;
        it.flow_y      = fy;
        return it;
    endfunction

    // Component mostly in a modest range, sometimes the full 16 bits.
    function automatic logic [15:0] rand_component();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 16'($urandom);
        if (roll < 15) return 16'h0000;
        if (roll < 60) return 16'($signed($urandom_range(0, 1023)) - 512);
        return 16'($signed($urandom_range(0, 16383)) - 8192);
    endfunction

    // One frame: clear the maximum, measure a few vectors, paint the same and more.
    task automatic random_frame(inout int items);
        t_in_item vecs[$];
        t_in_item it;
        int       n;
        n = $urandom_range(2, 8);
        for (int i = 0; i < n; i++) begin
            it = make_item(FUNC_MEASURE, i == 0, rand_component(), rand_component());
            vecs.insert(vecs.size(), it);
            send_with_gap(it);
            items++;
        end
        for (int i = 0; i < n + 2; i++) begin
            if (i < n && $urandom_range(0, 3) != 0) it = vecs[i];
            else it = make_item(FUNC_MEASURE, 1'b0, rand_component(), rand_component());
            it.func = FUNC_PAINT;
            it.frame_start = 1'($urandom);
            send_with_gap(it);
            items++;
        end
    endtask

    // ---------------------------------------------------------------- checker

    // Toggle output readiness at random; sometimes hold it low for a stretch.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n || !out_stall_enable) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 9) < 3) begin
            i_out_ready <= 1'b0;
            stall_left  <= gap_length();
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare every accepted color against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_colors.size() == 0) begin
                $display("%0t: unexpected color, expected none, actual %h", $time, o_out);
                fail_count++;
            end else begin
                want = pending_colors.pop_front();
                if (o_out.red !== want.red || o_out.green !== want.green ||
                    o_out.blue !== want.blue || o_out.unknown !== want.unknown) begin
                    $display("%0t: color mismatch, expected r%0d g%0d b%0d u%0d, actual r%0d g%0d b%0d u%0d",
                             $time, want.red, want.green, want.blue, want.unknown,
                             o_out.red, o_out.green, o_out.blue, o_out.unknown);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    typedef struct {
        logic        func;
        logic        start;
        logic [15:0] fx;
        logic [15:0] fy;
        bit          typed;  // expected color typed in below
        t_out_item   want;
    } t_table_row;

    localparam t_out_item BLACK_UNKNOWN = '{red: 8'd0, green: 8'd0, blue: 8'd0, unknown: 1'b1};
    localparam t_out_item ANY_COLOR     = '0;

    t_table_row directed[] = '{
        // paint right after reset: maximum is zero, so black/unknown
        '{FUNC_PAINT,   1'b0, 16'd100,  16'd0,    1'b1, BLACK_UNKNOWN},
        '{FUNC_MEASURE, 1'b1, 16'd320,  16'd0,    1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'd0,    16'd0,    1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
        '{FUNC_PAINT,   1'b0, 16'd320,  16'd0,    1'b1, '{8'd255, 8'd0, 8'd0, 1'b0}},
        '{FUNC_PAINT,   1'b0, 16'd160,  16'd0,    1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b1, 16'd0,    16'd320,  1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'hFEC0, 16'd0,    1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'd0,    16'hFEC0, 1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'd640,  16'd640,  1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'h8000, 16'd0,    1'b1, BLACK_UNKNOWN},
        '{FUNC_PAINT,   1'b0, 16'd5,    16'h8000, 1'b1, BLACK_UNKNOWN},
        '{FUNC_MEASURE, 1'b0, 16'h8000, 16'h8000, 1'b0, ANY_COLOR},
        '{FUNC_MEASURE, 1'b0, 16'h7FFF, 16'h7FFF, 1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'h7FFF, 16'h7FFF, 1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'h8001, 16'h7FFF, 1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'hFFFF, 16'h0001, 1'b0, ANY_COLOR},
        '{FUNC_MEASURE, 1'b1, 16'd1,    16'd0,    1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'h7FFF, 16'h8001, 1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'h00AA, 16'hFF55, 1'b0, ANY_COLOR},
        '{FUNC_MEASURE, 1'b1, 16'h8000, 16'd3,    1'b0, ANY_COLOR},
        '{FUNC_PAINT,   1'b0, 16'd1,    16'd1,    1'b1, BLACK_UNKNOWN}
    };

    initial begin
        int        items;
        t_in_item  it;
        t_out_item color;
        logic      norm;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_in             = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        fail_count       = 0;
        out_stall_enable = 1'b0;
        shadow_limit      = LIMIT_RST;
        shadow_norm       = 1'b1;
        shadow_max_radius = 16'd0;
        idle_cycles(6);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; typed rows also cross-check the predictor.
        foreach (directed[i]) begin
            it = make_item(directed[i].func, directed[i].start, directed[i].fx, directed[i].fy);
            send_item(it);
            if (directed[i].typed) begin
                color = pending_colors[$];
                if (color !== directed[i].want) begin
                    $display("%0t: table row %0d, expected %h, actual prediction %h",
                             $time, i, directed[i].want, color);
                    fail_count++;
                end
                pending_colors[$] = directed[i].want;
            end
        end

        // Unit divisor, and both extremes of the limit.
        set_regs(15'd32767, 1'b0);
        send_item(make_item(FUNC_PAINT, 1'b0, 16'd32, 16'd0));
        send_item(make_item(FUNC_PAINT, 1'b0, 16'd64, 16'd0));
        set_regs(15'd0, 1'b1);
        send_item(make_item(FUNC_MEASURE, 1'b1, 16'd0, 16'd0));
        send_item(make_item(FUNC_PAINT, 1'b0, 16'd0, 16'd0));
        send_item(make_item(FUNC_PAINT, 1'b0, 16'd1, 16'd0));
        set_regs(15'd0, 1'b0);
        send_item(make_item(FUNC_PAINT, 1'b0, 16'd0, 16'd0));
        set_regs(15'h5555, 1'b1);
        send_item(make_item(FUNC_MEASURE, 1'b1, 16'h5555, 16'h5556));
        send_item(make_item(FUNC_PAINT, 1'b0, 16'h5555, 16'd0));
        set_regs(15'h2AAA, 1'b1);
        send_item(make_item(FUNC_PAINT, 1'b0, 16'h2AAA, 16'hD556));

        // Random phases, with output stalls, sometimes under fresh register values.
        out_stall_enable = 1'b1;
        items = 0;
        while (items < 950) begin
            if ($urandom_range(0, 3) == 0) begin
                norm = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 3))
                    0: set_regs(15'd32767, norm);
                    1: set_regs(15'($urandom_range(0, 32767)), norm);
                    2: set_regs(15'($urandom_range(100, 9000)), norm);
                    default: set_regs(15'($urandom_range(0, 40)), norm);
                endcase
            end
            if ($urandom_range(0, 4) == 0) begin
                // Noise: lone items of either kind.
                it = make_item(1'($urandom), 1'($urandom), rand_component(), rand_component());
                send_with_gap(it);
                items++;
            end else begin
                random_frame(items);
            end
            // Hold off the sender until the output side has caught up.
            if ($urandom_range(0, 19) == 0) drain();
        end

        drain();
        idle_cycles(200);
        if (fail_count == 0 && pending_colors.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
